@@ rtl/core/lbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lbsa_pkg
// Shared constants and helper functions of the skinning accumulator.
// ----------------------------------------------------------------------------
package lbsa_pkg;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_POS    = 2'd1;
  localparam logic [1:0] FUNC_NRM    = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;
  localparam logic [3:0] ELEM_COUNT  = 4'd12;
  localparam logic       KIND_POS    = 1'b0;
  localparam logic       KIND_NRM    = 1'b1;

  // Floor shift right by 16 of a signed product (arithmetic shift floors).
  function automatic logic signed [47:0] shr16(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v >>> 16;
    return s[47:0];
  endfunction

  // Saturate to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ rtl/core/lbsa_table.sv @@
// ----------------------------------------------------------------------------
// lbsa_table
// Joint matrix memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbsa_table #(
  parameter int DEPTH = 768,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // Write and read in one clocked block; read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/linear_blend_skin_accumulate_core.sv @@
// ----------------------------------------------------------------------------
// linear_blend_skin_accumulate_core
// Skinning accumulator: matrix table, sequenced multiply-accumulate.
// ----------------------------------------------------------------------------
// channel | dir | fields (tdata low bit up)
// s_axis  | in  | tuser=func; tdata=index,bx,by,bz,joint,weight,element,value
// m_axis  | out | tuser=kind; tdata=index,x,y,z
// A matrix write is taken in idle and leaves the input open. Once accepted,
// an influence keeps the input closed while it latches the base, steps through
// the twelve elements from the single table port, takes three weight steps
// and loads the result.
// Reset clears the sequencer and the run bases and sums; the item latches and the table are not cleared.
// A held result stalls the sequencer in its last step until the sink takes it.
module linear_blend_skin_accumulate_core
  import lbsa_pkg::*;
#(
  parameter int MAX_JOINTS = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // func
  // target_index[15:0], base_x, base_y, base_z, joint[6], weight[17],
  // element[4], element_value[32], zero fill
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic         m_axis_tuser,   // kind
  // result_index[15:0], out_x, out_y, out_z
  output logic [111:0] m_axis_tdata
);

  localparam int DEPTH = MAX_JOINTS * 12;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MAC = 4'b0010, S_WGT = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state;
  logic [1:0] func;
  logic [INDEX_BITS-1:0] idx;
  logic signed [31:0] bin [3];
  logic [5:0]  joint;
  logic [16:0] weight;
  logic [3:0]  rcnt;      // element being requested
  logic [3:0]  pcnt;      // element arriving
  logic        pvalid;
  logic        jvalid;
  logic signed [49:0] t [3];
  logic signed [31:0] base [3];
  logic [1:0]  wcnt;

  logic [INDEX_BITS-1:0] pos_prev, nrm_prev;
  logic pos_started, nrm_started;
  logic signed [31:0] pos_base [3], nrm_base [3];
  logic signed [31:0] pos_sum [3], nrm_sum [3];

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [31:0]   tbl_rdata;
  logic [AW+5:0] wa_full, ra_full;

  assign s_axis_tready = (state == S_IDLE);
  assign wa_full = (AW+6)'(s_axis_tdata[117:112]) * (AW+6)'(12)
                   + (AW+6)'(s_axis_tdata[138:135]);
  assign tbl_we  = s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_WRITE
                   && int'(s_axis_tdata[117:112]) < MAX_JOINTS
                   && s_axis_tdata[138:135] < ELEM_COUNT;
  assign tbl_waddr = wa_full[AW-1:0];
  assign ra_full = (AW+6)'(joint) * (AW+6)'(12) + (AW+6)'(rcnt);
  assign tbl_raddr = ra_full[AW-1:0];

  lbsa_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(s_axis_tdata[170:139]),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  // Product of the arriving element with its base component
  logic signed [31:0] mel;
  logic [1:0] col, row;
  logic signed [63:0] prod;
  logic signed [49:0] addend;
  logic signed [31:0] tsat;
  logic signed [48:0] wprod;
  logic signed [31:0] cur_sum;
  logic signed [49:0] nsum;
  logic new_run;

  assign mel  = jvalid ? tbl_rdata : 32'sd0;
  assign col  = pcnt[1:0];
  assign row  = pcnt[3:2];
  assign prod = mel * base[col];
  always_comb begin
    if (col == 2'd3)
      addend = (func == FUNC_POS) ? 50'(mel) : 50'sd0;
    else
      addend = 50'(shr16(prod));
  end
  assign tsat    = sat32(t[wcnt]);
  assign wprod   = tsat * $signed({1'b0, weight});
  assign cur_sum = (func == FUNC_POS) ? pos_sum[wcnt] : nrm_sum[wcnt];
  assign nsum    = 50'(cur_sum) + 50'(wprod >>> 16);
  assign new_run = (func == FUNC_POS) ? (!pos_started || idx != pos_prev)
                                      : (!nrm_started || idx != nrm_prev);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos_started <= 1'b0; nrm_started <= 1'b0;
      pos_prev <= '0; nrm_prev <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_base[i] <= '0; nrm_base[i] <= '0;
        pos_sum[i] <= '0; nrm_sum[i] <= '0;
      end
    end else begin
      // Load the result register when free, drop valid once taken
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && (s_axis_tuser == FUNC_POS || s_axis_tuser == FUNC_NRM)) begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          // Latch base on a new run, then step elements
          if (!pvalid) begin
            if (new_run) begin
              for (int i = 0; i < 3; i++) begin
                if (func == FUNC_POS) begin
                  pos_base[i] <= bin[i]; pos_sum[i] <= '0;
                end else begin
                  nrm_base[i] <= bin[i]; nrm_sum[i] <= '0;
                end
              end
              if (func == FUNC_POS) begin
                pos_prev <= idx; pos_started <= 1'b1;
              end else begin
                nrm_prev <= idx; nrm_started <= 1'b1;
              end
            end
          end else begin
            t[row] <= ((col == 2'd0) ? 50'sd0 : t[row]) + addend;
            if (pcnt == 4'd11) state <= S_WGT;
          end
        end
        S_WGT: begin
          if (func == FUNC_POS) pos_sum[wcnt] <= sat32(nsum);
          else nrm_sum[wcnt] <= sat32(nsum);
          if (wcnt == 2'd2) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tuser  <= (func == FUNC_POS) ? KIND_POS : KIND_NRM;
            m_axis_tdata  <= {(func == FUNC_POS) ? pos_sum[2] : nrm_sum[2],
                              (func == FUNC_POS) ? pos_sum[1] : nrm_sum[1],
                              (func == FUNC_POS) ? pos_sum[0] : nrm_sum[0],
                              16'(idx)};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture item and step counters
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      func    <= s_axis_tuser;
      idx     <= INDEX_BITS'(s_axis_tdata[15:0]);
      bin[0]  <= s_axis_tdata[47:16];
      bin[1]  <= s_axis_tdata[79:48];
      bin[2]  <= s_axis_tdata[111:80];
      joint   <= s_axis_tdata[117:112];
      weight  <= s_axis_tdata[134:118];
      rcnt <= '0; pvalid <= 1'b0; wcnt <= '0;
    end else if (state == S_MAC) begin
      if (!pvalid) begin
        for (int i = 0; i < 3; i++)
          base[i] <= new_run ? bin[i]
                     : ((func == FUNC_POS) ? pos_base[i] : nrm_base[i]);
      end
      pvalid <= 1'b1;
      pcnt   <= rcnt;
      if (rcnt != 4'd11) rcnt <= rcnt + 4'd1;
      jvalid <= int'(joint) < MAX_JOINTS;
    end else if (state == S_WGT) begin
      wcnt <= wcnt + 2'd1;
    end
  end

endmodule

@@ rtl/core/lbsa_checker.sv @@
// ----------------------------------------------------------------------------
// lbsa_checker
// Port-level checks of the skinning accumulator.
// ----------------------------------------------------------------------------
module lbsa_port_checker
  import lbsa_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic         m_axis_tuser,
  input logic [111:0] m_axis_tdata
);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // An accepted influence keeps the input closed on the next cycle
  a_influence_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready
    && (s_axis_tuser == FUNC_POS || s_axis_tuser == FUNC_NRM)
    |=> !s_axis_tready)
    else $error("input accepted during influence");

  // No output right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result beat during reset");

endmodule

bind linear_blend_skin_accumulate_core lbsa_port_checker u_lbsa_checker (.*);
